/* rtl/core/som_bmu_pkg.sv */
// ----------------------------------------------------------------------------
// som_bmu_pkg
// Shared constants, types and field positions for the best matching unit
// classifier: neuron count, fixed-point widths, register indexes and the
// packing of the request and response beats.
// ----------------------------------------------------------------------------
package som_bmu_pkg;

   // map size and feature count
   localparam int NEURONS  = 512;
   localparam int FEATURES = 4;
   localparam int ADDR_W   = $clog2(NEURONS);

   // fixed-point widths
   localparam int FEAT_W   = 32;                 // raw feature, Q16.16
   localparam int SCALE_W  = 24;                 // reciprocal range, Q8.16
   localparam int WEIGHT_W = 18;                 // normalized value, Q2.16
   localparam int LABEL_W  = 2;
   localparam int INDEX_W  = 9;
   localparam int DIFF_W   = FEAT_W + 1;
   localparam int PROD_W   = 58;                 // full scaled product with rounding
   localparam int SQ_W     = 36;                 // square of a 19-bit difference
   localparam int DIST_W   = SQ_W + $clog2(FEATURES);

   // one memory entry: four weights with the label on top
   localparam int MEM_W    = FEATURES * WEIGHT_W + LABEL_W;

   // saturation and rounding of the scaled product
   localparam logic signed [PROD_W-1:0] P_SAT_HI    = 58'sd8589934592;
   localparam logic signed [PROD_W-1:0] P_SAT_LO    = -58'sd4294967296;
   localparam logic signed [PROD_W-1:0] ROUND_HALF  = 58'sd32768;
   localparam logic signed [WEIGHT_W-1:0] SAT_HIGH  = 18'sd131071;
   localparam logic signed [WEIGHT_W-1:0] SAT_LOW   = -18'sd65536;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_HR  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_VAR = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_PC  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_RR  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_HR   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_VAR  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_PC   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_RR   = 3'd7;

   // item kind carried in req_tuser
   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_CLASSIFY = 1'b1;

   // request beat packing
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_W_LSB     = REQ_IDX_LSB + INDEX_W;
   localparam int REQ_LABEL_LSB = REQ_W_LSB + FEATURES * WEIGHT_W;
   localparam int REQ_F_LSB     = REQ_LABEL_LSB + LABEL_W;
   localparam int REQ_DATA_W    = ((REQ_F_LSB + FEATURES * FEAT_W + 7) / 8) * 8;

   // response beat packing
   localparam int RSP_LABEL_LSB = 0;
   localparam int RSP_IDX_LSB   = RSP_LABEL_LSB + LABEL_W;
   localparam int RSP_DATA_W    = ((RSP_IDX_LSB + INDEX_W + 7) / 8) * 8;

   typedef logic [SQ_W-1:0] sq_type;

   // tag that travels with each neuron through the scan pipeline
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic [ADDR_W-1:0]  idx;
      logic [LABEL_W-1:0] label;
   } scan_tag_type;

endpackage

/* rtl/core/som_bmu_lane.sv */
// ----------------------------------------------------------------------------
// som_bmu_lane
// One feature lane: min-max scaling of the raw feature into Q2.16 with
// rounding and saturation, then the squared difference to the weight that
// the scan presents each cycle.
// ----------------------------------------------------------------------------
module som_bmu_lane (
   input  logic                                     clock,
   input  logic                                     start,
   input  logic signed [som_bmu_pkg::FEAT_W-1:0]    feature,
   input  logic signed [som_bmu_pkg::FEAT_W-1:0]    offset,
   input  logic        [som_bmu_pkg::SCALE_W-1:0]   scale,
   input  logic signed [som_bmu_pkg::WEIGHT_W-1:0]  weight,
   output som_bmu_pkg::sq_type                      sq
);
   import som_bmu_pkg::*;

   logic signed [DIFF_W-1:0]             diff_ff, diff_in;
   logic        [15+SCALE_W:0]           pp_lo_ff, pp_lo_in;
   logic signed [DIFF_W-16+SCALE_W:0]    pp_hi_ff, pp_hi_in;
   logic signed [PROD_W-1:0]             prod;
   logic signed [WEIGHT_W-1:0]           scaled_ff, scaled_in;
   logic signed [WEIGHT_W:0]             delta;
   logic signed [2*WEIGHT_W+1:0]         delta_sq;
   sq_type                               sq_ff, sq_in;

   // exact difference to the feature minimum, latched when a classify starts
   assign diff_in = DIFF_W'(feature) - DIFF_W'(offset);

   // product split into a low and a signed high partial product
   assign pp_lo_in = (16+SCALE_W)'(diff_ff[15:0]) * (16+SCALE_W)'(scale);
   assign pp_hi_in = (DIFF_W-15+SCALE_W)'(signed'(diff_ff[DIFF_W-1:16]))
                     * (DIFF_W-15+SCALE_W)'(signed'({1'b0, scale}));

   // recombine, round half up, saturate to [-1, 2)
   always_comb begin
      prod = (PROD_W'(pp_hi_ff) <<< 16) + signed'(PROD_W'(pp_lo_ff)) + ROUND_HALF;
      if (prod >= P_SAT_HI) begin
         scaled_in = SAT_HIGH;
      end else if (prod < P_SAT_LO) begin
         scaled_in = SAT_LOW;
      end else begin
         scaled_in = prod[16+WEIGHT_W-1:16];
      end
   end

   // squared distance component for the neuron being scanned
   assign delta    = (WEIGHT_W+1)'(scaled_ff) - (WEIGHT_W+1)'(weight);
   assign delta_sq = delta * delta;
   assign sq_in    = delta_sq[SQ_W-1:0];

   always_ff @(posedge clock) begin
      if (start) begin
         diff_ff <= diff_in;
      end
      pp_lo_ff  <= pp_lo_in;
      pp_hi_ff  <= pp_hi_in;
      scaled_ff <= scaled_in;
      sq_ff     <= sq_in;
   end

   assign sq = sq_ff;

endmodule

/* rtl/core/som_bmu_merge.sv */
// ----------------------------------------------------------------------------
// som_bmu_merge
// Adds the lane squares into one distance per neuron and keeps the running
// minimum; the lowest index wins a tie. Pulses done with the winner after
// the last neuron has been compared.
// ----------------------------------------------------------------------------
module som_bmu_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  som_bmu_pkg::sq_type                 sq [som_bmu_pkg::FEATURES],
   input  som_bmu_pkg::scan_tag_type           tag,
   output logic                                done,
   output logic [som_bmu_pkg::ADDR_W-1:0]      best_idx,
   output logic [som_bmu_pkg::LABEL_W-1:0]     best_label
);
   import som_bmu_pkg::*;

   logic [DIST_W-1:0]   sum_ff, sum_in;
   scan_tag_type        tag_ff;
   logic [DIST_W-1:0]   best_dist_ff;
   logic [ADDR_W-1:0]   best_idx_ff;
   logic [LABEL_W-1:0]  best_label_ff;
   logic                done_ff;
   logic                take;

   // sum of the lane squares
   always_comb begin
      sum_in = '0;
      for (int f = 0; f < FEATURES; f++) begin
         sum_in = sum_in + DIST_W'(sq[f]);
      end
   end

   // strict compare keeps the earlier neuron on a tie
   assign take = tag_ff.valid && (tag_ff.first || (sum_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         tag_ff.valid <= tag.valid;
         done_ff      <= tag_ff.valid && tag_ff.last;
      end
      tag_ff.first <= tag.first;
      tag_ff.last  <= tag.last;
      tag_ff.idx   <= tag.idx;
      tag_ff.label <= tag.label;
      sum_ff       <= sum_in;
      if (take) begin
         best_dist_ff  <= sum_ff;
         best_idx_ff   <= tag_ff.idx;
         best_label_ff <= tag_ff.label;
      end
   end

   assign done       = done_ff;
   assign best_idx   = best_idx_ff;
   assign best_label = best_label_ff;

endmodule

/* rtl/core/som_best_matching_unit_classifier.sv */
// ----------------------------------------------------------------------------
// som_best_matching_unit_classifier
// Self-organizing map classifier: finds the neuron nearest to a scaled
// feature vector and returns its index and cluster label.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one beat per item. req_tuser = 0 loads one neuron (weights
//   and label) into the map memory; req_tuser = 1 classifies four features.
//   rsp channel: one beat per classify item, none per load.
//   csr port: offsets (index 0..3) and reciprocal ranges (index 4..7), to be
//   written only while the block is idle; the block itself does not enforce this.
// Sequence and throughput
//   A load is taken every cycle while the block is idle. A classify holds
//   req_tready low through the scaling, one memory read per neuron over the
//   scan, the drain of the read, square, sum and compare stages, and the
//   hand-off of the result, which waits while the output register is full.
//   A classify with zero heart rate or variability skips scaling and scan.
//   The single read port of the map memory sets the scan length.
// Reset and stall
//   Reset returns offsets to 0 and scales to 1.0 and drops rsp_tvalid; the
//   map memory keeps no reset value and each neuron must be loaded before use.
//   The result sits in an output register: new loads are taken while it waits,
//   a finished classify waits until rsp_tready frees that register.
// ----------------------------------------------------------------------------
module som_best_matching_unit_classifier (
   input  logic                                   clock,
   input  logic                                   reset,
   // request beat
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: neuron_index, weight_heart_rate, weight_variability,
   // weight_phasic_conductance, weight_response_rate, cluster_label,
   // feature_heart_rate, feature_variability, feature_phasic_conductance,
   // feature_response_rate, zero fill
   input  logic [som_bmu_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: mode
   input  logic                                   req_tuser,
   // response beat
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata: class_label, winner_index, zero fill
   output logic [som_bmu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: error
   output logic                                   rsp_tuser,
   // configuration writes
   input  logic                                   csr_we,
   input  logic [som_bmu_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [som_bmu_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import som_bmu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SCAN,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic                       scale_cnt_ff, scale_cnt_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic                       err_ff, err_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]         rsp_label_ff, rsp_label_in;
   logic [INDEX_W-1:0]         rsp_idx_ff, rsp_idx_in;
   logic                       rsp_err_ff, rsp_err_in;

   logic signed [FEAT_W-1:0]   offset_ff [FEATURES];
   logic [SCALE_W-1:0]         scale_ff [FEATURES];

   logic [MEM_W-1:0]           map_mem [NEURONS];
   logic [MEM_W-1:0]           rd_data_ff;
   scan_tag_type               tag_rd_ff, tag_rd_in;
   scan_tag_type               tag_sq_ff, tag_sq_in;

   sq_type                     lane_sq [FEATURES];
   logic                       merge_done;
   logic [ADDR_W-1:0]          merge_idx;
   logic [LABEL_W-1:0]         merge_label;

   logic                       req_beat;
   logic                       load_beat;
   logic                       class_beat;
   logic                       missing;
   logic                       scanning;
   logic                       last_addr;
   logic [ADDR_W-1:0]          load_addr;
   logic                       load_in_range;

   // handshake decode
   assign req_tready    = (state_ff == ST_IDLE);
   assign req_beat      = req_tvalid && req_tready;
   assign load_beat     = req_beat && (req_tuser == MODE_LOAD);
   assign class_beat    = req_beat && (req_tuser == MODE_CLASSIFY);
   assign missing       = (req_tdata[REQ_F_LSB +: FEAT_W] == '0)
                       || (req_tdata[REQ_F_LSB + FEAT_W +: FEAT_W] == '0);
   assign scanning      = (state_ff == ST_SCAN);
   assign last_addr     = (addr_ff == ADDR_W'(NEURONS - 1));
   assign load_addr     = ADDR_W'(req_tdata[REQ_IDX_LSB +: INDEX_W]);
   assign load_in_range = (32'(req_tdata[REQ_IDX_LSB +: INDEX_W]) < 32'(NEURONS));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < FEATURES; f++) begin
            offset_ff[f] <= '0;
            scale_ff[f]  <= SCALE_W'(65536);
         end
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_OFFSET_HR:  offset_ff[0] <= csr_wdata;
            CSR_OFFSET_VAR: offset_ff[1] <= csr_wdata;
            CSR_OFFSET_PC:  offset_ff[2] <= csr_wdata;
            CSR_OFFSET_RR:  offset_ff[3] <= csr_wdata;
            CSR_SCALE_HR:   scale_ff[0]  <= csr_wdata[SCALE_W-1:0];
            CSR_SCALE_VAR:  scale_ff[1]  <= csr_wdata[SCALE_W-1:0];
            CSR_SCALE_PC:   scale_ff[2]  <= csr_wdata[SCALE_W-1:0];
            CSR_SCALE_RR:   scale_ff[3]  <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // map memory: one write per load beat, one registered read per scan cycle
   always_ff @(posedge clock) begin
      if (load_beat && load_in_range) begin
         map_mem[load_addr] <= {req_tdata[REQ_LABEL_LSB +: LABEL_W],
                                req_tdata[REQ_W_LSB +: FEATURES * WEIGHT_W]};
      end
      rd_data_ff <= map_mem[addr_ff];
   end

   // scan tags follow the read data, then the lane squares
   always_comb begin
      tag_rd_in.valid = scanning;
      tag_rd_in.first = (addr_ff == '0);
      tag_rd_in.last  = last_addr;
      tag_rd_in.idx   = addr_ff;
      tag_rd_in.label = '0;
      tag_sq_in       = tag_rd_ff;
      tag_sq_in.label = rd_data_ff[MEM_W-1 -: LABEL_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_rd_ff.valid <= 1'b0;
         tag_sq_ff.valid <= 1'b0;
      end else begin
         tag_rd_ff.valid <= tag_rd_in.valid;
         tag_sq_ff.valid <= tag_sq_in.valid;
      end
      tag_rd_ff.first <= tag_rd_in.first;
      tag_rd_ff.last  <= tag_rd_in.last;
      tag_rd_ff.idx   <= tag_rd_in.idx;
      tag_rd_ff.label <= tag_rd_in.label;
      tag_sq_ff.first <= tag_sq_in.first;
      tag_sq_ff.last  <= tag_sq_in.last;
      tag_sq_ff.idx   <= tag_sq_in.idx;
      tag_sq_ff.label <= tag_sq_in.label;
   end

   // one lane per feature
   for (genvar g = 0; g < FEATURES; g++) begin : g_lane
      som_bmu_lane u_lane (
         .clock   (clock),
         .start   (class_beat),
         .feature (req_tdata[REQ_F_LSB + FEAT_W * g +: FEAT_W]),
         .offset  (offset_ff[g]),
         .scale   (scale_ff[g]),
         .weight  (rd_data_ff[WEIGHT_W * g +: WEIGHT_W]),
         .sq      (lane_sq[g])
      );
   end

   // distance sum and running minimum
   som_bmu_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .sq         (lane_sq),
      .tag        (tag_sq_ff),
      .done       (merge_done),
      .best_idx   (merge_idx),
      .best_label (merge_label)
   );

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      scale_cnt_in = scale_cnt_ff;
      addr_in      = addr_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_label_in = rsp_label_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (class_beat) begin
               err_in       = missing;
               scale_cnt_in = 1'b0;
               addr_in      = '0;
               state_in     = missing ? ST_DONE : ST_SCALE;
            end
         end
         ST_SCALE: begin
            scale_cnt_in = 1'b1;
            if (scale_cnt_ff) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (last_addr) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (merge_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_label_in = err_ff ? '0 : merge_label;
               rsp_idx_in   = err_ff ? '0 : INDEX_W'(merge_idx);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scale_cnt_ff <= scale_cnt_in;
      addr_ff      <= addr_in;
      err_ff       <= err_in;
      rsp_label_ff <= rsp_label_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_idx_ff, rsp_label_ff});

endmodule

/* rtl/core/som_bmu_checker.sv */
// ----------------------------------------------------------------------------
// som_bmu_checker
// Port-level checks of the classifier: loads never stall the request side,
// a classify holds it off, a fresh result comes as the request side reopens,
// error results carry no winner, and a stalled response holds.
// ----------------------------------------------------------------------------
module som_bmu_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [som_bmu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                                rsp_tuser
);
   import som_bmu_pkg::*;

   // a load beat leaves the request side open
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == MODE_LOAD)) |=> req_tready)
      else $error("request side closed after a load beat");

   // a classify beat closes the request side
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == MODE_CLASSIFY)) |=> !req_tready)
      else $error("request side open during a classify");

   // a fresh result appears together with the reopening of the request side
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $rose(req_tready))
      else $error("result appeared outside the end of a classify");

   // an error result names no neuron and no label
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("error result carries a winner");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind som_best_matching_unit_classifier som_bmu_checker u_som_bmu_checker (.*);
